// ===== rtl/core/pira_pkg.sv =====
package pira_pkg;

    // Default storage depth and fixed field widths
    localparam int DEPTH_DEF = 32;
    localparam int ENTRY_W   = 32;
    localparam int POS_W     = 6;
    localparam int LEN_W     = 6;
    // Count width: wide enough for a length of up to 64 entries
    localparam int CNT_W     = 7;

    localparam logic [LEN_W-1:0] LEN_RESET = 6'd32;

    // Operation codes; the fourth code is unused and reads as invalid
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2
    } pira_op_t;

    // Update request from the top level to the entry array
    typedef struct packed {
        logic               insert;
        logic               remove;
        logic [POS_W-1:0]   pos;
        logic [ENTRY_W-1:0] value;
    } pira_cmd_t;

endpackage

// ===== rtl/core/pira_entry_array.sv =====
module pira_entry_array
    import pira_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  pira_cmd_t                        cmd,
    input  logic [CNT_W-1:0]                 count,
    output logic [DEPTH-1:0][ENTRY_W-1:0]    entries
);

    logic [DEPTH-1:0][ENTRY_W-1:0] entry_reg;
    logic [DEPTH-1:0][ENTRY_W-1:0] entry_next;
    logic [CNT_W-1:0]              pos_ext;

    assign pos_ext = {{(CNT_W-POS_W){1'b0}}, cmd.pos};

    // Work out each entry's next value from its neighbours
    for (genvar i = 0; i < DEPTH; i++) begin : g_entry
        logic from_below;
        logic from_above;
        logic take_below;
        logic take_above;

        if (i > 0) begin : g_below
            assign from_below = 1'b1;
        end
        else begin : g_no_below
            assign from_below = 1'b0;
        end

        if (i < DEPTH - 1) begin : g_above
            assign from_above = 1'b1;
        end
        else begin : g_no_above
            assign from_above = 1'b0;
        end

        assign take_below = cmd.insert && from_below
                            && (CNT_W'(i) > pos_ext) && (CNT_W'(i) < count);
        assign take_above = cmd.remove && from_above
                            && (CNT_W'(i) >= pos_ext) && (CNT_W'(i + 1) < count);

        always_comb
        begin
            entry_next[i] = entry_reg[i];
            if (cmd.insert && (CNT_W'(i) == pos_ext))
            begin
                entry_next[i] = cmd.value;
            end
            else if (take_below)
            begin
                entry_next[i] = entry_reg[(i > 0) ? i - 1 : 0];
            end
            else if (take_above)
            begin
                entry_next[i] = entry_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
            else if (cmd.remove && (CNT_W'(i + 1) == count))
            begin
                entry_next[i] = '0;
            end
        end
    end

    // Hold the entries; clear all of them at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entries = entry_reg;

endmodule

// ===== rtl/core/pira_dup_check.sv =====
module pira_dup_check
    import pira_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                             clk,
    input  logic                             enable,
    input  logic [DEPTH-1:0][ENTRY_W-1:0]    entries,
    input  logic [CNT_W-1:0]                 count,
    output logic                             any_equal
);

    logic [DEPTH-1:0] row_reg;
    logic [DEPTH-1:0] row_next;

    // Compare each entry with every later entry in use
    for (genvar i = 0; i < DEPTH; i++) begin : g_row
        always_comb
        begin
            row_next[i] = 1'b0;
            for (int j = i + 1; j < DEPTH; j++)
            begin
                if ((CNT_W'(j) < count) && (entries[i] == entries[j]))
                begin
                    row_next[i] = 1'b1;
                end
            end
        end
    end

    // Hold the row flags while the pipeline is stalled
    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            row_reg <= row_next;
        end
    end

    assign any_equal = |row_reg;

endmodule

// ===== rtl/core/positional_insert_remove_array.sv =====
// Positional insert/remove array with a duplicate check.
// Input channel (in_valid/in_ready) carries one word: op, position, value.
// Insert shifts the entries from position up one place, losing the last
// entry in use; remove shifts the entries above position down one place
// and clears the last entry in use; read returns the entry at position.
// Output channel (out_valid/out_ready) returns status, read_value and
// duplicate_found, the last being computed on the array after the step.
// Configuration: cfg_wr_en/cfg_wr_data write length_in_use, saturated to
// DEPTH; write it only while no word is in flight.
// From accept to result a word passes three registered stages: the array
// and the first status stage load as the word is accepted, then the
// pairwise comparison rows and the second status stage, then the result
// register. One word is accepted every cycle while the output is taken.
// A stall on out_ready freezes all three stages and drops in_ready.
// Reset clears every entry to zero, sets the length to 32 and empties the
// pipeline.
module positional_insert_remove_array
    import pira_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           op,
    input  logic [POS_W-1:0]     position,
    input  logic signed [31:0]   value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 status,
    output logic signed [31:0]   read_value,
    output logic                 duplicate_found,
    input  logic                 cfg_wr_en,
    input  logic [LEN_W-1:0]     cfg_wr_data
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [LEN_W-1:0]              len_reg;
    logic [CNT_W-1:0]              len_ext;
    logic [CNT_W-1:0]              count;
    logic                          advance;
    logic                          accept;
    logic                          pos_ok;
    logic                          op_ok;
    pira_cmd_t                     cmd;
    logic [DEPTH-1:0][ENTRY_W-1:0] entries;
    logic [ENTRY_W-1:0]            rd_data;
    logic                          dup_any;

    logic                          s1_valid_reg;
    logic                          s1_status_reg;
    logic [ENTRY_W-1:0]            s1_read_reg;
    logic                          s2_valid_reg;
    logic                          s2_status_reg;
    logic [ENTRY_W-1:0]            s2_read_reg;
    logic                          out_valid_reg;
    logic                          out_status_reg;
    logic [ENTRY_W-1:0]            out_read_reg;
    logic                          out_dup_reg;

    // Hold the length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            len_reg <= cfg_wr_data;
        end
    end

    // Saturate the length to the depth
    assign len_ext = {{(CNT_W-LEN_W){1'b0}}, len_reg};
    assign count   = (len_ext > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : len_ext;

    // Advance the whole pipeline unless the result is stalled
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;
    assign accept   = in_valid && advance;

    // Decode the word
    assign pos_ok = {{(CNT_W-POS_W){1'b0}}, position} < count;

    always_comb
    begin
        op_ok      = 1'b0;
        cmd.insert = 1'b0;
        cmd.remove = 1'b0;
        cmd.pos    = position;
        cmd.value  = value;
        unique case (pira_op_t'(op))
            OP_INSERT: begin
                op_ok      = 1'b1;
                cmd.insert = accept && pos_ok;
            end
            OP_REMOVE: begin
                op_ok      = 1'b1;
                cmd.remove = accept && pos_ok;
            end
            OP_READ: begin
                op_ok = 1'b1;
            end
            default: begin
                op_ok = 1'b0;
            end
        endcase
    end

    pira_entry_array #(
        .DEPTH (DEPTH)
    ) u_array (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .count   (count),
        .entries (entries)
    );

    assign rd_data = entries[position[IW-1:0]];

    pira_dup_check #(
        .DEPTH (DEPTH)
    ) u_dup (
        .clk       (clk),
        .enable    (advance),
        .entries   (entries),
        .count     (count),
        .any_equal (dup_any)
    );

    // Advance the valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // Advance the result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_status_reg  <= !(pos_ok && op_ok);
            s1_read_reg    <= (pos_ok && (pira_op_t'(op) == OP_READ)) ? rd_data : '0;
            s2_status_reg  <= s1_status_reg;
            s2_read_reg    <= s1_read_reg;
            out_status_reg <= s2_status_reg;
            out_read_reg   <= s2_read_reg;
            out_dup_reg    <= dup_any;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign read_value      = out_read_reg;
    assign duplicate_found = out_dup_reg;

endmodule

// ===== rtl/core/pira_checker.sv =====
module pira_checker
    import pira_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_ready,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 status,
    input  logic signed [31:0]   read_value,
    input  logic                 duplicate_found
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
                                    && $stable(read_value) && $stable(duplicate_found))
        else $error("result word changed while stalled");

    // An invalid step never returns data
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> read_value == 32'sd0)
        else $error("invalid step returned a nonzero read value");

    // An empty output stage never blocks the input
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no result pending");

    // A taken result frees the input in the same cycle
    a_ready_taken: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> in_ready)
        else $error("input stalled while the result is taken");

endmodule

bind positional_insert_remove_array pira_checker u_pira_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .read_value      (read_value),
    .duplicate_found (duplicate_found)
);
